### hw/rtl/gf128m_pkg.sv
`timescale 1ns / 1ps
// Shared types and carry-less multiply helpers for the GF(2^128) multiplier.
package gf128m_pkg;

    // Partial products of one 64x64 carry-less product, split at 32 bits.
    typedef struct packed {
        logic [63:0] hh;
        logic [63:0] mid;
        logic [63:0] ll;
    } part_t;

    // The three Karatsuba products: low halves, high halves, XOR of halves.
    typedef struct packed {
        part_t sum;
        part_t hi;
        part_t lo;
    } part_set_t;

    // 32x32 carry-less multiply, 64-bit result.
    function automatic logic [63:0] clmul32(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            if (y[i]) begin
                acc = acc ^ ({32'b0, x} << i);
            end
        end
        return acc;
    endfunction

    // Split a 64x64 carry-less product into its 32-bit partial products.
    function automatic part_t clmul64_parts(input logic [63:0] x, input logic [63:0] y);
        part_t p;
        p.ll  = clmul32(x[31:0], y[31:0]);
        p.hh  = clmul32(x[63:32], y[63:32]);
        p.mid = clmul32(x[31:0], y[63:32]) ^ clmul32(x[63:32], y[31:0]);
        return p;
    endfunction

    // Join partial products into the 128-bit carry-less product.
    function automatic logic [127:0] parts_join(input part_t p);
        return {p.hh, p.ll} ^ ({64'b0, p.mid} << 32);
    endfunction

endpackage

### hw/rtl/gf128m_pp_stage.sv
`timescale 1ns / 1ps
// First pipeline stage: 32x32 carry-less partial products for all three Karatsuba terms.
module gf128m_pp_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [63:0]            a_low,
    input  logic [63:0]            a_high,
    input  logic [63:0]            b_low,
    input  logic [63:0]            b_high,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gf128m_pkg::part_set_t  out_parts
);

    logic                  valid_reg;
    logic                  valid_next;
    gf128m_pkg::part_set_t parts_reg;
    gf128m_pkg::part_set_t parts_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next     = in_ready ? in_valid : valid_reg;
        parts_next.lo  = gf128m_pkg::clmul64_parts(a_low, b_low);
        parts_next.hi  = gf128m_pkg::clmul64_parts(a_high, b_high);
        parts_next.sum = gf128m_pkg::clmul64_parts(a_low ^ a_high, b_low ^ b_high);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load on accept only, hold otherwise.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            parts_reg <= parts_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_parts = parts_reg;

endmodule

### hw/rtl/gf128m_kara_stage.sv
`timescale 1ns / 1ps
// Second pipeline stage: join partial products and apply the Karatsuba combine to 256 bits.
module gf128m_kara_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gf128m_pkg::part_set_t in_parts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [255:0]          out_wide
);

    logic         valid_reg;
    logic         valid_next;
    logic [255:0] wide_reg;
    logic [255:0] wide_next;
    logic [127:0] d0;
    logic [127:0] d1;
    logic [127:0] d2;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        d0         = gf128m_pkg::parts_join(in_parts.lo);
        d2         = gf128m_pkg::parts_join(in_parts.hi);
        d1         = gf128m_pkg::parts_join(in_parts.sum) ^ d0 ^ d2;
        wide_next  = {d2, d0} ^ ({128'b0, d1} << 64);
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            wide_reg <= wide_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_wide  = wide_reg;

endmodule

### hw/rtl/gf128m_red_stage.sv
`timescale 1ns / 1ps
// Third pipeline stage: reduce the 256-bit product modulo x^128 + x^7 + x^2 + x + 1.
module gf128m_red_stage (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [255:0] in_wide,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  prod_low,
    output logic [63:0]  prod_high
);

    logic         valid_reg;
    logic         valid_next;
    logic [127:0] res_reg;
    logic [127:0] res_next;
    logic [63:0]  w0;
    logic [63:0]  w1;
    logic [63:0]  w2;
    logic [63:0]  w3;
    logic [63:0]  ovf;
    logic [63:0] r0;
    logic [63:0] r1;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        w0  = in_wide[63:0];
        w1  = in_wide[127:64];
        w2  = in_wide[191:128];
        w3  = in_wide[255:192];
        r0  = w0 ^ w2 ^ (w2 << 1) ^ (w2 << 2) ^ (w2 << 7);
        r1  = w1 ^ w3 ^ (w3 << 1) ^ (w3 << 2) ^ (w3 << 7)
              ^ (w2 >> 63) ^ (w2 >> 62) ^ (w2 >> 57);
        // fold the bits that overflowed past x^127 once more
        ovf = (w3 >> 63) ^ (w3 >> 62) ^ (w3 >> 57);
        r0  = r0 ^ ovf ^ (ovf << 1) ^ (ovf << 2) ^ (ovf << 7);
        res_next   = {r1, r0};
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod_low  = res_reg[63:0];
    assign prod_high = res_reg[127:64];

endmodule

### hw/rtl/gf128_multiply_core.sv
`timescale 1ns / 1ps
// Top level of the GF(2^128) Karatsuba multiplier.
//
// Multiplies two elements of GF(2^128) in polynomial basis, plain bit order
// (bit i is the coefficient of x^i), modulo x^128 + x^7 + x^2 + x + 1. Each
// operand arrives as a low and a high 64-bit half; the result leaves the
// same way. One item in gives one item out, with no dependence between
// items, so the block takes a new item in every cycle unless m_ready
// stalls the output. An accepted item passes through three register
// stages in order and leaves when m_valid and m_ready are both high.
// The stages are a partial-product stage (twelve 32x32 carry-less
// products), a Karatsuba join stage and a reduction stage, whose register
// is the output register. Each stage carries its own valid bit and stalls
// only when it is full and its successor is not ready, so m_ready
// back-pressure propagates combinationally to s_ready and bubbles are
// squeezed out; no item is dropped or repeated under any stall pattern.
// The block keeps no state between items and needs no clearing after reset.
module gf128_multiply_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_a_low,
    input  logic [63:0] s_a_high,
    input  logic [63:0] s_b_low,
    input  logic [63:0] s_b_high,
    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_prod_low,
    output logic [63:0] m_prod_high
);

    // Stage 1 -> stage 2
    logic                  pp_valid;
    logic                  kara_ready;
    gf128m_pkg::part_set_t pp_parts;

    // Stage 2 -> stage 3
    logic                  kara_valid;
    logic                  red_ready;
    logic [255:0]          kara_wide;

    // Partial products: the three Karatsuba terms, each as four 32x32 products
    gf128m_pp_stage u_pp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .a_low     (s_a_low),
        .a_high    (s_a_high),
        .b_low     (s_b_low),
        .b_high    (s_b_high),
        .out_valid (pp_valid),
        .out_ready (kara_ready),
        .out_parts (pp_parts)
    );

    // Join and combine: form the full 256-bit carry-less product
    gf128m_kara_stage u_kara (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pp_valid),
        .in_ready  (kara_ready),
        .in_parts  (pp_parts),
        .out_valid (kara_valid),
        .out_ready (red_ready),
        .out_wide  (kara_wide)
    );

    // Reduction: fold the upper 128 bits back, hold the result for the sink
    gf128m_red_stage u_red (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (kara_valid),
        .in_ready  (red_ready),
        .in_wide   (kara_wide),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .prod_low  (m_prod_low),
        .prod_high (m_prod_high)
    );

endmodule

### hw/rtl/gf128m_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the GF(2^128) multiplier, with its bind to the top level.
module gf128m_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [63:0] s_a_low,
    input logic [63:0] s_a_high,
    input logic [63:0] s_b_low,
    input logic [63:0] s_b_high,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_prod_low,
    input logic [63:0] m_prod_high
);

    // Hold a stalled result item unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prod_low) && $stable(m_prod_high))
        else $error("result item changed while stalled");

    // Drop all items on reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty output stage means the whole pipeline can advance.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // Zero operand gives a zero result when the sink keeps draining.
    a_zero_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready
            && (((s_a_low == 64'd0) && (s_a_high == 64'd0))
                || ((s_b_low == 64'd0) && (s_b_high == 64'd0))))
            ##1 m_ready ##1 m_ready
        |=> m_valid && (m_prod_low == 64'd0) && (m_prod_high == 64'd0))
        else $error("zero operand did not give zero after three cycles");

endmodule

bind gf128_multiply_core gf128m_checker u_gf128m_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_a_low     (s_a_low),
    .s_a_high    (s_a_high),
    .s_b_low     (s_b_low),
    .s_b_high    (s_b_high),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_prod_low  (m_prod_low),
    .m_prod_high (m_prod_high)
);
